>>> hw/rtl/divider_timer_with_reload_defines.svh
// Assertion macros for the divider timer RTL, used by dtr_core.
// Expects clk and rst_n in scope where a macro is used.
`ifndef DIVIDER_TIMER_WITH_RELOAD_DEFINES_SVH
`define DIVIDER_TIMER_WITH_RELOAD_DEFINES_SVH

// Check cons in the cycle after ante.
`define DTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check cons in the same cycle as ante.
`define DTR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dtr_pkg.sv
// Types, codes and constants for the divider timer with reload.
// No dependencies; used by dtr_core and divider_timer_with_reload.
package dtr_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_DIV  = 2'd0,
        REG_TIMA = 2'd1,
        REG_TMA  = 2'd2,
        REG_TAC  = 2'd3
    } sel_t;

    typedef struct packed {
        op_t        op;
        sel_t       sel;
        logic [7:0] wdata;
        logic       hs;
    } item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic       seq;
    } result_t;

    localparam logic [15:0] DIV_RESET  = 16'h0006;
    localparam logic [15:0] DIV_STEP   = 16'h0004;
    localparam logic [7:0]  CTRL_FILL  = 8'hF8;
    localparam int          SEQ_BIT_SLOW = 12;
    localparam int          SEQ_BIT_FAST = 13;
    localparam int          TAP_W      = 10;

    function automatic logic [TAP_W-1:0] tap_of(input logic [1:0] rate);
        logic [TAP_W-1:0] m;
        case (rate)
            2'd0:    m = TAP_W'(1 << 9);
            2'd1:    m = TAP_W'(1 << 3);
            2'd2:    m = TAP_W'(1 << 5);
            default: m = TAP_W'(1 << 7);
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/dtr_core.sv
// Timer state and per-item update: divider, counter, modulo, control, reload.
// Depends on dtr_pkg and divider_timer_with_reload_defines.svh.
`include "divider_timer_with_reload_defines.svh"

module dtr_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  dtr_pkg::item_t   item,
    output dtr_pkg::result_t result
);

    logic [15:0]               div_reg, div_next;
    logic [7:0]                tc_reg, tc_next;
    logic [7:0]                mod_reg, mod_next;
    logic [2:0]                ctrl_reg, ctrl_next;
    logic                      on_reg, on_next;
    logic [dtr_pkg::TAP_W-1:0] tap_reg, tap_next;
    logic                      pend_reg, pend_next;
    logic                      jr_reg, jr_next;

    logic [15:0]               div_new;
    logic [dtr_pkg::TAP_W-1:0] new_tap;
    logic                      mv;

    always_comb
    begin
        div_next  = div_reg;
        tc_next   = tc_reg;
        mod_next  = mod_reg;
        ctrl_next = ctrl_reg;
        on_next   = on_reg;
        tap_next  = tap_reg;
        pend_next = pend_reg;
        jr_next   = jr_reg;
        result    = '0;
        mv        = 1'b0;
        div_new   = div_reg;
        new_tap   = dtr_pkg::tap_of(item.wdata[1:0]);

        case (item.op)
            dtr_pkg::OP_TICK:
            begin
                jr_next = 1'b0;
                if (pend_reg)
                begin
                    tc_next    = mod_reg;
                    result.irq = 1'b1;
                    pend_next  = 1'b0;
                    jr_next    = 1'b1;
                end
                mv      = 1'b1;
                div_new = div_reg + dtr_pkg::DIV_STEP;
            end
            dtr_pkg::OP_READ:
            begin
                case (item.sel)
                    dtr_pkg::REG_DIV:  result.rdata = div_reg[15:8];
                    dtr_pkg::REG_TIMA: result.rdata = tc_reg;
                    dtr_pkg::REG_TMA:  result.rdata = mod_reg;
                    default:           result.rdata = dtr_pkg::CTRL_FILL | {5'd0, ctrl_reg};
                endcase
            end
            dtr_pkg::OP_WRITE:
            begin
                case (item.sel)
                    dtr_pkg::REG_DIV:
                    begin
                        mv      = 1'b1;
                        div_new = '0;
                    end
                    dtr_pkg::REG_TIMA:
                    begin
                        pend_next = 1'b0;
                        if (!jr_reg)
                            tc_next = item.wdata;
                    end
                    dtr_pkg::REG_TMA:
                    begin
                        mod_next = item.wdata;
                        if (jr_reg)
                            tc_next = item.wdata;
                    end
                    default:
                    begin
                        ctrl_next = item.wdata[2:0];
                        // glitch increment when the selected tap drops out
                        if (on_reg && (|(div_reg[dtr_pkg::TAP_W-1:0] & tap_reg)) &&
                            (!item.wdata[2] || !(|(div_reg[dtr_pkg::TAP_W-1:0] & new_tap))))
                        begin
                            tc_next = tc_reg + 8'd1;
                            if (tc_next == 8'd0)
                            begin
                                tc_next    = mod_reg;
                                result.irq = 1'b1;
                                pend_next  = 1'b0;
                                jr_next    = 1'b1;
                            end
                        end
                        on_next  = item.wdata[2];
                        tap_next = new_tap;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (mv)
        begin
            if (on_reg && !(|(div_new[dtr_pkg::TAP_W-1:0] & tap_reg)) &&
                (|(div_reg[dtr_pkg::TAP_W-1:0] & tap_reg)))
            begin
                tc_next = tc_next + 8'd1;
                if (tc_next == 8'd0)
                    pend_next = 1'b1;
            end
            if (item.hs)
                result.seq = div_reg[dtr_pkg::SEQ_BIT_FAST] & ~div_new[dtr_pkg::SEQ_BIT_FAST];
            else
                result.seq = div_reg[dtr_pkg::SEQ_BIT_SLOW] & ~div_new[dtr_pkg::SEQ_BIT_SLOW];
            div_next = div_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg  <= dtr_pkg::DIV_RESET;
            tc_reg   <= '0;
            mod_reg  <= '0;
            ctrl_reg <= '0;
            on_reg   <= 1'b0;
            tap_reg  <= '0;
            pend_reg <= 1'b0;
            jr_reg   <= 1'b0;
        end
        else if (en)
        begin
            div_reg  <= div_next;
            tc_reg   <= tc_next;
            mod_reg  <= mod_next;
            ctrl_reg <= ctrl_next;
            on_reg   <= on_next;
            tap_reg  <= tap_next;
            pend_reg <= pend_next;
            jr_reg   <= jr_next;
        end
    end

    `DTR_ASSERT_NEXT(a_irq_marks_reload, en && result.irq, jr_reg, "irq without reload mark")
    `DTR_ASSERT_NEXT(a_read_keeps_state, en && item.op == dtr_pkg::OP_READ, $stable(div_reg) && $stable(tc_reg) && $stable(pend_reg) && $stable(jr_reg), "read changed timer state")
    `DTR_ASSERT_SAME(a_seq_needs_move, en && item.op != dtr_pkg::OP_TICK && !(item.op == dtr_pkg::OP_WRITE && item.sel == dtr_pkg::REG_DIV), !result.seq, "sequencer clock without divider move")
    `DTR_ASSERT_SAME(a_rdata_only_read, en && item.op != dtr_pkg::OP_READ, result.rdata == 8'd0, "read data outside a read")

endmodule

>>> hw/rtl/divider_timer_with_reload.sv
// Divider timer with delayed reload: stream wrapper around dtr_core.
// Depends on dtr_pkg and dtr_core.
//
// Usage:
//   Slave channel (s_*) takes one operation per item: a tick of one machine
//   cycle, a register read or a register write. Master channel (m_*) gives
//   exactly one result item per operation, in order.
//   An item is held in the input register, its result in the output register.
//   Throughput: one item per clock unless m_tready stalls; the state update
//   is a single pass of add, edge detect and compare between those registers.
//   Reset: divider at 6, counter, modulo and control at 0, timer off, no
//   tap selected, no reload pending; both channels empty.
//   Stall: while a result waits on m_tready, one further item is held in
//   the input register; s_tready drops only when both registers are full.
//   Read data is zero except on a read; control reads back with the upper
//   five bits set.
module divider_timer_with_reload (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] high_speed, [15:9] zero
    input  logic [3:0]  s_tuser,   // [1:0] opcode, [3:2] reg_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_data, [8] irq_pulse, [9] sequencer_clock
);

    logic              in_valid_reg, in_valid_next;
    dtr_pkg::item_t    in_item_reg;
    logic              out_valid_reg, out_valid_next;
    dtr_pkg::result_t  out_res_reg;
    dtr_pkg::result_t  res;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op    <= dtr_pkg::op_t'(s_tuser[1:0]);
            in_item_reg.sel   <= dtr_pkg::sel_t'(s_tuser[3:2]);
            in_item_reg.wdata <= s_tdata[7:0];
            in_item_reg.hs    <= s_tdata[8];
        end
        if (advance)
            out_res_reg <= res;
    end

    dtr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (in_item_reg),
        .result (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.seq, out_res_reg.irq, out_res_reg.rdata};

endmodule
